@@ src/rdc_pkg.sv @@
// Package for the radix digit converter: shared types, constants and helpers.
`default_nettype none
package rdc_pkg;

    // Digit stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int RADIX_W     = 5;
    localparam int COUNT_W     = 6;

    // Radix limits and reset value
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // ASCII codes
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SHOW,
        S_WAIT
    } t_state;

    // Divider control from the sequencer
    typedef struct packed {
        logic load;   // take a new value and start dividing it
        logic again;  // divide the current quotient once more
    } t_div_ctrl;

    // Divider status back to the sequencer
    typedef struct packed {
        logic               done;
        logic               q_zero;
        logic [DIGIT_W-1:0] rem;
    } t_div_stat;

    // Digit stack write request
    typedef struct packed {
        logic                we;
        logic [STACK_AW-1:0] addr;
        logic [DIGIT_W-1:0]  data;
    } t_stack_wr;

    // Digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/rdc_div_unit.sv @@
// Iterative divider: quotient by a small radix, four quotient bits per cycle.
`default_nettype none
module rdc_div_unit #(
    parameter int QUO_W = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rdc_pkg::t_div_ctrl          i_ctrl,
    input  wire logic [QUO_W-1:0]            i_value,
    input  wire logic [rdc_pkg::RADIX_W-1:0] i_radix,
    output rdc_pkg::t_div_stat               o_stat
);

    localparam int STEPS = QUO_W / 4;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic [QUO_W-1:0]            r_quo, n_quo;
    logic [rdc_pkg::DIGIT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    // Four restoring steps: shift in a dividend bit, subtract radix if it fits
    always_comb begin
        logic [rdc_pkg::DIGIT_W:0]   t;
        logic [rdc_pkg::DIGIT_W-1:0] rem;
        logic [3:0]                  qbits;
        logic [QUO_W+3:0]            shifted;
        rem   = r_rem;
        qbits = '0;
        for (int k = 0; k < 4; k++) begin
            t = {rem, r_quo[QUO_W-1-k]};
            if (t >= i_radix) begin
                qbits[3-k] = 1'b1;
                t          = t - i_radix;
            end
            rem = t[rdc_pkg::DIGIT_W-1:0];
        end
        shifted = {r_quo, qbits};
        n_quo   = shifted[QUO_W-1:0];
        n_rem   = rem;
    end

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_ctrl.load || i_ctrl.again) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Datapath: quotient shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quo <= i_value;
            r_rem <= '0;
        end else if (i_ctrl.again) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.q_zero = (r_quo == '0);
    assign o_stat.rem    = r_rem;

endmodule
`default_nettype wire

@@ src/rdc_digit_stack.sv @@
// Digit stack: 32 x 4 memory, one write port, registered read.
`default_nettype none
module rdc_digit_stack (
    input  wire logic                         i_clk,
    input  wire rdc_pkg::t_stack_wr           i_wr,
    input  wire logic [rdc_pkg::STACK_AW-1:0] i_raddr,
    output logic      [rdc_pkg::DIGIT_W-1:0]  o_rdata
);

    logic [rdc_pkg::DIGIT_W-1:0] r_mem [rdc_pkg::STACK_DEPTH];
    logic [rdc_pkg::DIGIT_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/radix_digit_converter_unit.sv @@
// Top level of the radix digit converter: sequencer, radix register, output register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | i_value[31:0]
//  output  | out       | o_valid / i_stall  | o_digit_char[6:0], o_last_digit
//  config  | in        | i_cfg_we           | i_cfg_data[4:0] (radix)
//
// Each digit comes from one division in the shared divider (value width at most
// 32 bits); the digits are then read back from the stack and presented.
// Synchronous active-low reset; radix resets to 10. o_stall is high from the
// accepted request until the last digit is taken; i_stall simply holds a digit.
`default_nettype none
module radix_digit_converter_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [6:0]       o_digit_char,
    output logic             o_last_digit,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data
);

    localparam int QW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int QP = ((QW + 3) / 4) * 4;

    rdc_pkg::t_state    r_state, n_state;
    rdc_pkg::t_div_ctrl w_div_ctrl;
    rdc_pkg::t_div_stat w_div_stat;
    rdc_pkg::t_stack_wr w_stack_wr;

    logic [rdc_pkg::RADIX_W-1:0]  r_radix;
    logic [rdc_pkg::RADIX_W-1:0]  w_radix;
    logic [rdc_pkg::COUNT_W-1:0]  r_count;
    logic [rdc_pkg::COUNT_W-1:0]  w_count_inc;
    logic [rdc_pkg::STACK_AW-1:0] r_ptr;
    logic [rdc_pkg::DIGIT_W-1:0]  w_rd_data;
    logic [QP-1:0]                w_value;
    logic                         w_finish;
    logic                         w_out_load;
    logic                         w_pop;
    logic                         r_out_valid;
    logic [rdc_pkg::CHAR_W-1:0]   r_char;
    logic                         r_last;

    // Radix register and clamp to 2..16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rdc_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    always_comb begin
        priority if (r_radix < rdc_pkg::RADIX_MIN) begin
            w_radix = rdc_pkg::RADIX_MIN;
        end else if (r_radix > rdc_pkg::RADIX_MAX) begin
            w_radix = rdc_pkg::RADIX_MAX;
        end else begin
            w_radix = r_radix;
        end
    end

    assign w_value     = QP'(i_value[QW-1:0]);
    assign w_count_inc = r_count + rdc_pkg::COUNT_W'(1);
    assign w_finish    = w_div_stat.q_zero ||
                         (w_count_inc == rdc_pkg::COUNT_W'(rdc_pkg::STACK_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                if (i_valid) n_state = rdc_pkg::S_DIV;
            end
            rdc_pkg::S_DIV: begin
                if (w_div_stat.done && w_finish) n_state = rdc_pkg::S_READ;
            end
            rdc_pkg::S_READ: n_state = rdc_pkg::S_SHOW;
            rdc_pkg::S_SHOW: n_state = rdc_pkg::S_WAIT;
            rdc_pkg::S_WAIT: begin
                if (!i_stall) begin
                    n_state = (r_ptr == '0) ? rdc_pkg::S_IDLE : rdc_pkg::S_READ;
                end
            end
            default: n_state = rdc_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_div_ctrl.load  = (r_state == rdc_pkg::S_IDLE) && i_valid;
        w_div_ctrl.again = (r_state == rdc_pkg::S_DIV) && w_div_stat.done && !w_finish;
        w_stack_wr.we    = (r_state == rdc_pkg::S_DIV) && w_div_stat.done;
        w_stack_wr.addr  = r_count[rdc_pkg::STACK_AW-1:0];
        w_stack_wr.data  = w_div_stat.rem;
        w_out_load       = (r_state == rdc_pkg::S_SHOW);
        w_pop            = (r_state == rdc_pkg::S_WAIT) && !i_stall;
        o_stall          = (r_state != rdc_pkg::S_IDLE);
    end

    // State, digit count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_div_ctrl.load) begin
                r_count <= '0;
            end else if (w_stack_wr.we) begin
                r_count <= w_count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stack_wr.we && w_finish) begin
            r_ptr <= r_count[rdc_pkg::STACK_AW-1:0];
        end else if (w_pop) begin
            r_ptr <= r_ptr - rdc_pkg::STACK_AW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_char <= rdc_pkg::to_ascii(w_rd_data);
            r_last <= (r_ptr == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    rdc_div_unit #(
        .QUO_W (QP)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .i_value (w_value),
        .i_radix (w_radix),
        .o_stat  (w_div_stat)
    );

    rdc_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_wr    (w_stack_wr),
        .i_raddr (r_ptr),
        .o_rdata (w_rd_data)
    );

endmodule
`default_nettype wire

@@ src/rdc_checker.sv @@
// Port-level checker for the radix digit converter, bound to the top level.
`default_nettype none
module rdc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_digit_char,
    input wire logic       o_last_digit
);

    // A stalled digit holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digit_char) && $stable(o_last_digit))
        else $error("stalled digit changed");

    // No new request is taken while a digit is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while digit pending");

    // Characters are 0-9 or A-F
    a_char_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= 7'h30) && (o_digit_char <= 7'h39)) ||
                    ((o_digit_char >= 7'h41) && (o_digit_char <= 7'h46)))
        else $error("illegal digit character");

    // A taken request produces no digit in the next cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("digit appeared too early");

    // After the last digit goes, the block is open again
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_digit |=> !o_stall && !o_valid)
        else $error("block not free after last digit");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digit_char (o_digit_char),
    .o_last_digit (o_last_digit)
);
`default_nettype wire

@@ dv/radix_digit_checker.sv @@
// Checker for the radix digit converter: predicts the digit stream of each request and compares it.
module radix_digit_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [31:0] i_req_value,
    input  wire logic        i_dig_valid,
    input  wire logic        i_dig_stall,
    input  wire logic [6:0]  i_dig_char,
    input  wire logic        i_dig_last,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_data,
    output int               o_outstanding,
    output int               o_fail_count
);

    // One predicted output character
    typedef struct packed {
        logic [rdc_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } t_digit;

    t_digit                      pending_digits[$];
    logic [rdc_pkg::RADIX_W-1:0] radix_shadow = rdc_pkg::RADIX_RESET;
    int                          fails = 0;

    // Digit value to ASCII: '0'..'9', then 'A'..'F'
    function automatic logic [rdc_pkg::CHAR_W-1:0] ascii_of(
        input logic [rdc_pkg::DIGIT_W-1:0] d
    );
        if (d < rdc_pkg::DIGIT_TEN) begin
            return rdc_pkg::ASCII_ZERO + rdc_pkg::CHAR_W'(d);
        end
        return rdc_pkg::ASCII_A + rdc_pkg::CHAR_W'(d - rdc_pkg::DIGIT_TEN);
    endfunction

    // Divide down by the clamped radix, then queue the digits MSB first
    task automatic predict_digits(input logic [31:0] value);
        logic [rdc_pkg::DIGIT_W-1:0] lsb_first[rdc_pkg::STACK_DEPTH];
        logic [31:0]                 quot;
        int unsigned                 base;
        int                          n;
        t_digit                      d;
        if (radix_shadow < rdc_pkg::RADIX_MIN) begin
            base = rdc_pkg::RADIX_MIN;
        end else if (radix_shadow > rdc_pkg::RADIX_MAX) begin
            base = rdc_pkg::RADIX_MAX;
        end else begin
            base = radix_shadow;
        end
        quot = value;
        n    = 0;
        do begin
            lsb_first[n] = rdc_pkg::DIGIT_W'(quot % base);
            quot         = quot / base;
            n++;
        end while (quot != 0 && n < rdc_pkg::STACK_DEPTH);
        for (int k = n - 1; k >= 0; k--) begin
            d.ch   = ascii_of(lsb_first[k]);
            d.last = (k == 0);
            pending_digits.insert(pending_digits.size(), d);
        end
    endtask

    // Watch both channels and the radix write at every edge
    always @(posedge i_clk) begin
        t_digit want;
        if (!i_rst_n) begin
            radix_shadow = rdc_pkg::RADIX_RESET;
            pending_digits.delete();
        end else begin
            if (i_cfg_we) begin
                radix_shadow = i_cfg_data;
            end
            // Output side first: it only ever drains older requests
            if (i_dig_valid && !i_dig_stall) begin
                if (pending_digits.size() == 0) begin
                    $display("%0t: unexpected digit: char=%h last=%b",
                             $time, i_dig_char, i_dig_last);
                    fails++;
                end else begin
                    want = pending_digits.pop_front();
                    if (i_dig_char !== want.ch) begin
                        $display("%0t: digit_char mismatch: expected %h, got %h",
                                 $time, want.ch, i_dig_char);
                        fails++;
                    end
                    if (i_dig_last !== want.last) begin
                        $display("%0t: last_digit mismatch: expected %b, got %b",
                                 $time, want.last, i_dig_last);
                        fails++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_digits(i_req_value);
            end
        end
        o_outstanding <= pending_digits.size();
        o_fail_count  <= fails;
    end

endmodule

@@ dv/radix_digit_converter_unit_test.sv @@
// Testbench top for the radix digit converter: clock, reset, stimulus and verdict.
module radix_digit_converter_unit_test;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 19;
    localparam int NUM_PHASES   = 8;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [31:0] i_value    = '0;
    logic        i_stall    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    wire         o_stall;
    wire         o_valid;
    wire  [6:0]  o_digit_char;
    wire         o_last_digit;
    int          outstanding;
    int          fail_count;

    // Idle rates in percent, set per phase
    int          tx_idle_pct = 13;
    int          rx_idle_pct = 50;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;

    radix_digit_converter_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    radix_digit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_value   (i_value),
        .i_dig_valid   (o_valid),
        .i_dig_stall   (i_stall),
        .i_dig_char    (o_digit_char),
        .i_dig_last    (o_last_digit),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Radix write once the block has drained
    task automatic write_radix(input logic [4:0] radix);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= radix;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mix of zero, all ones, full-width, short and tiny values
    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom;
            5, 6, 7: return $urandom >> $urandom_range(0, 31);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial begin
        logic [4:0] radix;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset radix of ten
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1_000_000_000);
        // Hex, including the letter digits
        write_radix(5'd16);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_000A);
        send_value(32'h0000_000F);
        send_value(32'h0000_0010);
        // Binary: longest digit string
        write_radix(5'd2);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd0);
        // Radix below two behaves as binary
        write_radix(5'd0);
        send_value(32'd5);
        send_value(32'hFFFF_FFFF);
        write_radix(5'd1);
        send_value(32'd6);
        // Radix above sixteen behaves as hex
        write_radix(5'd17);
        send_value(32'hABCD_EF01);
        write_radix(5'd31);
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        write_radix(5'd3);
        send_value(32'hFFFF_FFFF);

        // Random phases over several radix settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            unique case (ph)
                0:       radix = 5'd7;
                1:       radix = 5'd2;
                2:       radix = 5'd16;
                3:       radix = 5'd31;
                4:       radix = 5'd1;
                5:       radix = 5'($urandom_range(0, 31));
                6:       radix = 5'($urandom_range(2, 16));
                default: radix = 5'd10;
            endcase
            write_radix(radix);
            if (ph < 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 50;
            end else if (ph < 6) begin
                tx_idle_pct = 50;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while requests keep coming
                if (ph == 2 && n == 10) begin
                    hold_request = 1'b1;
                end
                send_value(pick_value());
            end
        end

        // Drain and verdict
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/rdc_pkg.sv
src/rdc_div_unit.sv
src/rdc_digit_stack.sv
src/radix_digit_converter_unit.sv
src/rdc_checker.sv
dv/radix_digit_checker.sv
dv/radix_digit_converter_unit_test.sv
